[rtl/core/ws_dfrm_pkg.sv]
// ----------------------------------------------------------------------------
// ws_dfrm_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package ws_dfrm_pkg;

  localparam int LEN_W   = 63;
  localparam int ACC_W   = 64;
  localparam int KEY_W   = 32;
  localparam int TDATA_W = 88;

  localparam logic [1:0] CFG_MAX_FRAME   = 2'd0;
  localparam logic [1:0] CFG_REQ_MASK    = 2'd1;
  localparam logic [1:0] CFG_CHECK_UTF8  = 2'd2;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OP    = 3'd1;
  localparam logic [2:0] ST_NO_MASK   = 3'd2;
  localparam logic [2:0] ST_PROTO     = 3'd3;
  localparam logic [2:0] ST_LEN_MSB   = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE = 3'd5;
  localparam logic [2:0] ST_BAD_UTF8  = 3'd6;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

endpackage

[rtl/core/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses an RFC 6455 byte stream into header, unmasked payload and error items.
// ----------------------------------------------------------------------------
// Usage: one received byte enters per in_ item (in_tdata). Each accepted byte
// gives zero or one out_ item: out_tuser is the kind (header complete, payload
// byte, error), out_tlast marks the item that completes a frame, out_tdata
// carries the unmasked byte, the frame header fields and a status code.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// A byte sits in the input register, is parsed from there and its result is
// loaded into the output register, which drives out_tvalid. Throughput is
// one byte per cycle while the receiver takes items; the parse state update
// and mask XOR are done in a single pass.
// When the receiver stalls, the output register holds its item, the input
// register takes one more byte and in_tready then drops until the output
// register is read.
// Reset (rst_n low, synchronous) returns the parser to the first header byte
// and loads the configuration defaults. After an error item the block keeps
// accepting bytes but gives no results until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input byte stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] in_byte
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] data_byte, [11:8] frame_opcode, [12] fin_flag, [15:13] rsv_bits,
  // [16] masked_flag, [79:17] frame_length, [82:80] status, [87:83] zero
  output logic [ws_dfrm_pkg::TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,  // frame_end
  output logic [1:0]                         out_tuser,  // [1:0] kind
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [ws_dfrm_pkg::LEN_W-1:0]      cfg_wdata
);
  import ws_dfrm_pkg::*;

  // configuration registers
  logic [LEN_W-1:0] max_frame_r;
  logic             req_mask_r;
  logic             chk_utf8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= LEN_W'(1048576);
      req_mask_r  <= 1'b0;
      chk_utf8_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FRAME:  max_frame_r <= cfg_wdata;
        CFG_REQ_MASK:   req_mask_r  <= cfg_wdata[0];
        CFG_CHECK_UTF8: chk_utf8_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output register state
  logic                out_valid_r;
  logic [TDATA_W-1:0]  out_data_r;
  logic                out_last_r;
  logic [1:0]          out_kind_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_free;
  logic       s1_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // parse state
  phase_t           phase_r,  phase_nxt;
  logic [3:0]       hbc_r,    hbc_nxt;
  logic             ext64_r,  ext64_nxt;
  logic [ACC_W-1:0] acc_r,    acc_nxt;
  logic [KEY_W-1:0] key_r,    key_nxt;
  logic [LEN_W-1:0] cnt_r,    cnt_nxt;
  logic [3:0]       op_r,     op_nxt;
  logic [4:0]       flags_r,  flags_nxt;   // fin, rsv[2:0], mask
  logic [1:0]       upend_r,  upend_nxt;
  logic             ubad_r,   ubad_nxt;

  // result of the current byte
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_data;
  logic       res_end;
  logic [2:0] res_status;

  // working values
  logic [7:0]       b;
  logic [6:0]       len7;
  logic             op_ok;
  logic [ACC_W-1:0] acc_shift;
  logic [3:0]       hbc_inc;
  logic [LEN_W-1:0] cnt_inc;
  logic             last;
  logic [7:0]       key_byte;
  logic [7:0]       d;
  logic             do_fail;
  logic [2:0]       fail_code;
  logic             do_after_len;
  logic             do_hdr_done;

  always_comb begin
    phase_nxt   = phase_r;
    hbc_nxt     = hbc_r;
    ext64_nxt   = ext64_r;
    acc_nxt     = acc_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    flags_nxt   = flags_r;
    upend_nxt   = upend_r;
    ubad_nxt    = ubad_r;
    res_valid   = 1'b0;
    res_kind    = KIND_HDR;
    res_data    = 8'd0;
    res_end     = 1'b0;
    res_status  = ST_OK;
    do_fail      = 1'b0;
    fail_code    = ST_OK;
    do_after_len = 1'b0;
    do_hdr_done  = 1'b0;

    b         = s1_byte_r;
    len7      = b[6:0];
    op_ok     = (op_r == OP_CONT) || (op_r == OP_TEXT) || (op_r == OP_BIN) ||
                (op_r == OP_CLOSE) || (op_r == OP_PING) || (op_r == OP_PONG);
    acc_shift = {acc_r[ACC_W-9:0], b};
    hbc_inc   = hbc_r + 4'd1;
    cnt_inc   = cnt_r + LEN_W'(1);
    last      = {1'b0, cnt_inc} >= acc_r;
    case (cnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    d = flags_r[0] ? (b ^ key_byte) : b;

    if (s1_fire) begin
      case (phase_r)
        PH_HDR0: begin
          op_nxt    = b[3:0];
          flags_nxt = {b[7], b[6:4], 1'b0};
          acc_nxt   = '0;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          flags_nxt = {flags_r[4:1], b[7]};
          acc_nxt   = ACC_W'(len7);
          if (!op_ok) begin
            do_fail   = 1'b1;
            fail_code = ST_BAD_OP;
          end else if (req_mask_r && !b[7]) begin
            do_fail   = 1'b1;
            fail_code = ST_NO_MASK;
          end else if (op_r[3] && (!flags_r[4] || len7 > LEN7_CTRL_MAX)) begin
            do_fail   = 1'b1;
            fail_code = ST_PROTO;
          end else if (len7 < LEN7_EXT16) begin
            do_after_len = 1'b1;
          end else begin
            ext64_nxt = (len7 != LEN7_EXT16);
            hbc_nxt   = 4'd0;
            acc_nxt   = '0;
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          acc_nxt = acc_shift;
          hbc_nxt = hbc_inc;
          if (hbc_inc >= (ext64_r ? 4'd8 : 4'd2)) begin
            if (!ext64_r && acc_shift < ACC_W'(126)) begin
              do_fail   = 1'b1;
              fail_code = ST_PROTO;
            end else if (ext64_r && acc_shift < ACC_W'(65536)) begin
              do_fail   = 1'b1;
              fail_code = ST_PROTO;
            end else if (ext64_r && acc_shift[ACC_W-1]) begin
              do_fail   = 1'b1;
              fail_code = ST_LEN_MSB;
            end else if (acc_shift > {1'b0, max_frame_r}) begin
              do_fail   = 1'b1;
              fail_code = ST_TOO_LARGE;
            end else begin
              do_after_len = 1'b1;
            end
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[KEY_W-9:0], b};
          hbc_nxt = hbc_inc;
          if (hbc_inc >= 4'd4) begin
            do_hdr_done = 1'b1;
          end
        end
        PH_PAY: begin
          cnt_nxt = cnt_inc;
          if (chk_utf8_r && op_r == OP_TEXT) begin
            // structural utf-8 check on the unmasked byte
            if (upend_r != 2'd0) begin
              if (d[7:6] != 2'b10) begin
                ubad_nxt  = 1'b1;
                upend_nxt = 2'd0;
              end else begin
                upend_nxt = upend_r - 2'd1;
              end
            end else if (!d[7]) begin
              upend_nxt = 2'd0;
            end else if (d[7:5] == 3'b110) begin
              upend_nxt = 2'd1;
            end else if (d[7:4] == 4'b1110) begin
              upend_nxt = 2'd2;
            end else if (d[7:3] == 5'b11110) begin
              upend_nxt = 2'd3;
            end else begin
              ubad_nxt = 1'b1;
            end
            if (last && (ubad_nxt || upend_nxt != 2'd0)) begin
              do_fail   = 1'b1;
              fail_code = ST_BAD_UTF8;
            end
          end
          if (!do_fail) begin
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_data  = d;
            res_end   = last;
            if (last) begin
              phase_nxt = PH_HDR0;
            end
          end
        end
        default: ;
      endcase

      if (do_after_len) begin
        hbc_nxt = 4'd0;
        key_nxt = '0;
        if (flags_nxt[0]) begin
          phase_nxt = PH_MASK;
        end else begin
          do_hdr_done = 1'b1;
        end
      end

      if (do_hdr_done) begin
        cnt_nxt   = '0;
        upend_nxt = 2'd0;
        ubad_nxt  = 1'b0;
        res_valid = 1'b1;
        res_kind  = KIND_HDR;
        // zero-length frame ends on its last header byte
        res_end   = (acc_nxt == '0);
        phase_nxt = (acc_nxt == '0) ? PH_HDR0 : PH_PAY;
      end

      if (do_fail) begin
        phase_nxt  = PH_HALT;
        res_valid  = 1'b1;
        res_kind   = KIND_ERR;
        res_data   = 8'd0;
        res_end    = 1'b0;
        res_status = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hbc_r   <= 4'd0;
      ext64_r <= 1'b0;
      acc_r   <= '0;
      key_r   <= '0;
      cnt_r   <= '0;
      op_r    <= 4'd0;
      flags_r <= 5'd0;
      upend_r <= 2'd0;
      ubad_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hbc_r   <= hbc_nxt;
      ext64_r <= ext64_nxt;
      acc_r   <= acc_nxt;
      key_r   <= key_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      flags_r <= flags_nxt;
      upend_r <= upend_nxt;
      ubad_r  <= ubad_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_data_r <= {5'd0, res_status, acc_nxt[LEN_W-1:0], flags_nxt[0],
                     flags_nxt[3:1], flags_nxt[4], op_nxt, res_data};
      out_last_r <= res_end;
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ERR) |-> (phase_r == PH_HALT))
    else $error("error item shown while parser is not halted");

  a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EXT) |-> (hbc_r < (ext64_r ? 4'd8 : 4'd2)))
    else $error("extended length byte count out of range");

  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> ({1'b0, cnt_r} < acc_r))
    else $error("payload count reached frame length inside payload phase");
`endif

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the websocket frame deframer. A short list of
// hand-picked bytes runs first, then random frames under several register
// settings (size limit at both extremes, masking forced, text checking on and
// off) with 7-bit and 16-bit lengths and one frame exactly at the size limit.
// Results are checked against a byte-level parser model kept in the bench,
// or against the typed rows of the list. Because an error halts the block
// until reset, the run ends with one frame built to fail, of a randomly
// chosen kind, followed by bytes that must give no result.
// ----------------------------------------------------------------------------
module tb_top;
  import ws_dfrm_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic        masked;
    logic [62:0] length;
    logic        last;
    logic [2:0]  status;
  } deframe_result_t;

  typedef struct {
    logic [7:0]      wire_byte;
    bit              typed;
    deframe_result_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = 8'h00;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic [1:0]         out_tuser;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_MAX_FRAME;
  logic [LEN_W-1:0]   cfg_wdata = '0;

  websocket_frame_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // parser model state
  phase_t      prs_phase;
  int unsigned hdr_cnt;
  int unsigned ext_len_bytes;
  logic [63:0] len_acc;
  logic [31:0] key;
  logic [62:0] pay_cnt;
  logic [3:0]  cur_op;
  logic        cur_fin;
  logic [2:0]  cur_rsv;
  logic        cur_mask;
  int unsigned utf_pending;
  bit          utf_bad;
  // register copies
  logic [62:0] lim_frame;
  bit          need_mask;
  bit          utf8_check;

  deframe_result_t expected_q[$];
  int mismatch_count = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int cyc = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  // hand-picked bytes; typed rows are the ones obvious from the frame format
  dir_row_t dir_rows [24] = '{
    '{8'h82, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_HDR, 8'h00, OP_BIN, 1'b1, 3'd0, 1'b0, 63'd0, 1'b1, ST_OK}},
    '{8'h89, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b1, '{KIND_HDR, 8'h00, OP_PING, 1'b1, 3'd0, 1'b1, 63'd0, 1'b1, ST_OK}},
    '{8'h81, 1'b0, '0},
    '{8'h85, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h34, 1'b0, '0},
    '{8'h56, 1'b0, '0},
    '{8'h78, 1'b1, '{KIND_HDR, 8'h00, OP_TEXT, 1'b1, 3'd0, 1'b1, 63'd5, 1'b0, ST_OK}},
    // masked text: a four-byte sequence then one ascii char
    '{8'hE2, 1'b0, '0},
    '{8'hAB, 1'b0, '0},
    '{8'hCE, 1'b0, '0},
    '{8'hF8, 1'b0, '0},
    '{8'h53, 1'b0, '0},
    // all rsv bits, no fin, continuation of one byte
    '{8'h70, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h88, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_HDR, 8'h00, OP_CLOSE, 1'b1, 3'd0, 1'b0, 63'd0, 1'b1, ST_OK}}
  };

  always @(posedge clk) cyc <= cyc + 1;

  // no idling at all in this window
  function automatic bit idle_roll();
    if (cyc >= 1000 && cyc < 1600) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  function automatic deframe_result_t make_res(input logic [1:0] kind, input logic [7:0] d,
                                               input logic last, input logic [2:0] st);
    deframe_result_t r;
    r.kind   = kind;
    r.data   = d;
    r.opcode = cur_op;
    r.fin    = cur_fin;
    r.rsv    = cur_rsv;
    r.masked = cur_mask;
    r.length = len_acc[62:0];
    r.last   = last;
    r.status = st;
    return r;
  endfunction

  function automatic deframe_result_t halt_with(input logic [2:0] st);
    prs_phase = PH_HALT;
    return make_res(KIND_ERR, 8'h00, 1'b0, st);
  endfunction

  function automatic deframe_result_t close_header();
    pay_cnt     = '0;
    utf_pending = 0;
    utf_bad     = 1'b0;
    if (len_acc == 0) begin
      prs_phase = PH_HDR0;
      return make_res(KIND_HDR, 8'h00, 1'b1, ST_OK);
    end
    prs_phase = PH_PAY;
    return make_res(KIND_HDR, 8'h00, 1'b0, ST_OK);
  endfunction

  function automatic bit length_done(output deframe_result_t r);
    hdr_cnt = 0;
    key     = '0;
    r       = '0;
    if (cur_mask) begin
      prs_phase = PH_MASK;
      return 1'b0;
    end
    r = close_header();
    return 1'b1;
  endfunction

  // advances the parser model by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output deframe_result_t r);
    logic [6:0] len7;
    logic [7:0] d;
    bit         fin_byte;
    r = '0;
    case (prs_phase)
      PH_HDR0: begin
        cur_op    = b[3:0];
        cur_fin   = b[7];
        cur_rsv   = b[6:4];
        cur_mask  = 1'b0;
        len_acc   = '0;
        prs_phase = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        len7     = b[6:0];
        cur_mask = b[7];
        len_acc  = {57'd0, len7};
        if (!(cur_op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG})) begin
          r = halt_with(ST_BAD_OP);
          return 1'b1;
        end
        if (need_mask && !cur_mask) begin
          r = halt_with(ST_NO_MASK);
          return 1'b1;
        end
        if (cur_op >= OP_CLOSE && (!cur_fin || len7 > LEN7_CTRL_MAX)) begin
          r = halt_with(ST_PROTO);
          return 1'b1;
        end
        if (len7 < LEN7_EXT16) return length_done(r);
        ext_len_bytes = (len7 == LEN7_EXT16) ? 2 : 8;
        hdr_cnt       = 0;
        len_acc       = '0;
        prs_phase     = PH_EXT;
        return 1'b0;
      end
      PH_EXT: begin
        len_acc = {len_acc[55:0], b};
        hdr_cnt++;
        if (hdr_cnt < ext_len_bytes) return 1'b0;
        if (ext_len_bytes == 2) begin
          if (len_acc < 126) begin
            r = halt_with(ST_PROTO);
            return 1'b1;
          end
        end else begin
          if (len_acc < 65536) begin
            r = halt_with(ST_PROTO);
            return 1'b1;
          end
          if (len_acc[63]) begin
            r = halt_with(ST_LEN_MSB);
            return 1'b1;
          end
        end
        if (len_acc > {1'b0, lim_frame}) begin
          r = halt_with(ST_TOO_LARGE);
          return 1'b1;
        end
        return length_done(r);
      end
      PH_MASK: begin
        key = {key[23:0], b};
        hdr_cnt++;
        if (hdr_cnt < 4) return 1'b0;
        r = close_header();
        return 1'b1;
      end
      PH_PAY: begin
        d = b;
        // first key byte received sits in the top byte
        if (cur_mask) d = d ^ key[8*(3 - pay_cnt[1:0]) +: 8];
        pay_cnt  = pay_cnt + 63'd1;
        fin_byte = ({1'b0, pay_cnt} >= len_acc);
        if (utf8_check && cur_op == OP_TEXT) begin
          if (utf_pending != 0) begin
            if (d[7:6] != 2'b10) begin
              utf_bad     = 1'b1;
              utf_pending = 0;
            end else begin
              utf_pending--;
            end
          end else if (d[7]) begin
            if (d[7:5] == 3'b110) utf_pending = 1;
            else if (d[7:4] == 4'b1110) utf_pending = 2;
            else if (d[7:3] == 5'b11110) utf_pending = 3;
            else utf_bad = 1'b1;
          end
          if (fin_byte && (utf_bad || utf_pending != 0)) begin
            r = halt_with(ST_BAD_UTF8);
            return 1'b1;
          end
        end
        if (fin_byte) prs_phase = PH_HDR0;
        r = make_res(KIND_DATA, d, fin_byte, ST_OK);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string fmt(input deframe_result_t r);
    return $sformatf("kind=%0d data=%02h op=%0h fin=%0b rsv=%0d mask=%0b len=%0d end=%0b st=%0d",
                     r.kind, r.data, r.opcode, r.fin, r.rsv, r.masked, r.length, r.last,
                     r.status);
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                           input deframe_result_t typed_res = '0);
    deframe_result_t r;
    bit              due;
    while (idle_roll()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due = parse_byte(b, r);
    if (use_typed) expected_q = {expected_q, typed_res};
    else if (due) expected_q = {expected_q, r};
    bytes_sent++;
  endtask

  task automatic apply_config(input logic [62:0] max_sz, input bit req_mask, input bit utf8_on);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_FRAME;
    cfg_wdata <= max_sz;
    @(posedge clk);
    cfg_index <= CFG_REQ_MASK;
    cfg_wdata <= {62'd0, req_mask};
    @(posedge clk);
    cfg_index <= CFG_CHECK_UTF8;
    cfg_wdata <= {62'd0, utf8_on};
    @(posedge clk);
    cfg_we     <= 1'b0;
    lim_frame  = max_sz;
    need_mask  = req_mask;
    utf8_check = utf8_on;
  endtask

  // wait for every result, then idle while the two-stage pipe empties
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_frame(input logic [3:0] op, input bit fin, input logic [2:0] rsv,
                            input bit m, input logic [63:0] len, input bit utf8_ok,
                            input bit bad_tail);
    logic [7:0]  plain[$];
    logic [31:0] k;
    int          body;
    int          n;
    int          i;
    push_byte({fin, rsv, op});
    if (len < 126) begin
      push_byte({m, len[6:0]});
    end else if (len < 65536) begin
      push_byte({m, LEN7_EXT16});
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else begin
      push_byte({m, 7'd127});
      for (i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
    end
    k = $urandom;
    if (m) for (i = 3; i >= 0; i--) push_byte(k[8*i +: 8]);
    body = int'(len) - int'(bad_tail);
    while (plain.size() < body) begin
      if (utf8_ok) begin
        n = body - plain.size();
        if (n > 4) n = 4;
        n = $urandom_range(1, n);
        case (n)
          1: plain = {plain, 8'($urandom_range(8'h00, 8'h7F))};
          2: plain = {plain, 8'($urandom_range(8'hC0, 8'hDF))};
          3: plain = {plain, 8'($urandom_range(8'hE0, 8'hEF))};
          default: plain = {plain, 8'($urandom_range(8'hF0, 8'hF7))};
        endcase
        repeat (n - 1) plain = {plain, 8'($urandom_range(8'h80, 8'hBF))};
      end else begin
        plain = {plain, 8'($urandom_range(0, 255))};
      end
    end
    // any high byte after complete sequences breaks utf-8 at the frame end
    if (bad_tail) plain = {plain, 8'($urandom_range(8'h80, 8'hFF))};
    foreach (plain[j]) push_byte(plain[j] ^ (m ? k[8*(3 - j % 4) +: 8] : 8'h00));
    if (!bad_tail) frames_sent++;
  endtask

  task automatic send_random_frame();
    logic [3:0] op;
    bit         fin;
    bit         m;
    bit         good;
    int         len;
    int         ext_cap;
    int         roll;
    if (lim_frame < 126) ext_cap = 0;
    else if (lim_frame > 300) ext_cap = 300;
    else ext_cap = int'(lim_frame);
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      case ($urandom_range(0, 2))
        0: op = OP_CLOSE;
        1: op = OP_PING;
        default: op = OP_PONG;
      endcase
      fin = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 15);
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_CONT;
        3: op = OP_BIN;
        default: op = OP_TEXT;
      endcase
      fin  = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(0, 20);
      else if (roll < 90 || ext_cap == 0) len = $urandom_range(21, 125);
      else len = $urandom_range(126, ext_cap);
    end
    m    = need_mask ? 1'b1 : 1'($urandom_range(0, 1));
    good = (op == OP_TEXT) && (utf8_check || $urandom_range(0, 1));
    send_frame(op, fin, 3'($urandom_range(0, 7)), m, 64'(len), good, 1'b0);
  endtask

  task automatic random_phase(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_frame();
  endtask

  // one frame that must halt the block
  task automatic send_fatal(input logic [2:0] code);
    logic [7:0]  b0;
    logic [62:0] lim;
    logic [15:0] l16;
    bit          m;
    int          v;
    int          i;
    lim = 63'd1048576;
    if (code == ST_TOO_LARGE) lim = 63'($urandom_range(126, 60000));
    apply_config(lim, code == ST_NO_MASK, 1'b1);
    m  = 1'($urandom_range(0, 1));
    b0 = 8'($urandom_range(0, 255));
    case (code)
      ST_BAD_OP: begin
        v = $urandom_range(0, 9);
        b0[3:0] = (v < 5) ? 4'(3 + v) : 4'(6 + v);
        push_byte(b0);
        push_byte(8'($urandom_range(0, 255)));
      end
      ST_NO_MASK: begin
        b0[3:0] = OP_BIN;
        push_byte(b0);
        push_byte({1'b0, 7'($urandom_range(0, 127))});
      end
      ST_PROTO: begin
        case ($urandom_range(0, 3))
          0: begin
            // control frame without fin
            push_byte({1'b0, b0[6:4], OP_PING});
            push_byte({m, 7'($urandom_range(0, 125))});
          end
          1: begin
            // control frame with an extended length field
            push_byte({1'b1, b0[6:4], OP_CLOSE});
            push_byte({m, 7'($urandom_range(126, 127))});
          end
          2: begin
            // 16-bit length that fits in 7 bits
            push_byte({1'b1, b0[6:4], OP_BIN});
            push_byte({m, LEN7_EXT16});
            push_byte(8'h00);
            push_byte(8'($urandom_range(0, 125)));
          end
          default: begin
            // 64-bit length that fits in 16 bits
            push_byte({1'b1, b0[6:4], OP_BIN});
            push_byte({m, 7'd127});
            repeat (6) push_byte(8'h00);
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
      ST_LEN_MSB: begin
        push_byte({1'b1, b0[6:4], OP_BIN});
        push_byte({m, 7'd127});
        push_byte({1'b1, 7'($urandom_range(0, 127))});
        for (i = 0; i < 7; i++) push_byte(8'($urandom_range(0, 255)));
      end
      ST_TOO_LARGE: begin
        l16 = 16'($urandom_range(int'(lim) + 1, 65535));
        push_byte({1'b1, b0[6:4], OP_TEXT});
        push_byte({m, LEN7_EXT16});
        push_byte(l16[15:8]);
        push_byte(l16[7:0]);
      end
      default: begin
        send_frame(OP_TEXT, b0[7], b0[6:4], m, 64'($urandom_range(1, 12)), 1'b1, 1'b1);
      end
    endcase
  endtask

  task automatic check_result();
    deframe_result_t got;
    deframe_result_t want;
    got = '{out_tuser, out_tdata[7:0], out_tdata[11:8], out_tdata[12], out_tdata[15:13],
            out_tdata[16], out_tdata[79:17], out_tlast, out_tdata[82:80]};
    results_seen++;
    if (expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected item: %s", fmt(got));
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch at item %0d", results_seen);
        $display("  expected %s", fmt(want));
        $display("  actual   %s", fmt(got));
      end
    end
  endtask

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!held_once && results_seen >= 200) begin
      out_tready <= 1'b0;
      hold_left  <= 400;
      held_once  <= 1'b1;
    end else begin
      out_tready <= !idle_roll();
    end
  end

  initial begin
    logic [62:0] lim;
    logic [2:0]  fatal_code;
    prs_phase     = PH_HDR0;
    hdr_cnt       = 0;
    ext_len_bytes = 2;
    len_acc       = '0;
    key           = '0;
    pay_cnt       = '0;
    cur_op        = OP_CONT;
    cur_fin       = 1'b0;
    cur_rsv       = 3'd0;
    cur_mask      = 1'b0;
    utf_pending   = 0;
    utf_bad       = 1'b0;
    lim_frame     = 63'd1048576;
    need_mask     = 1'b0;
    utf8_check    = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults
    foreach (dir_rows[r]) push_byte(dir_rows[r].wire_byte, dir_rows[r].typed, dir_rows[r].res);
    settle();

    apply_config(63'($urandom_range(300, 100000)), 1'b0, 1'b1);
    random_phase(450);
    settle();

    // widest size limit, masking forced, text unchecked
    apply_config(63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    random_phase(300);
    settle();

    // zero limit: only 7-bit lengths get through
    apply_config(63'd0, 1'b0, 1'b1);
    random_phase(250);
    settle();

    lim = 63'($urandom_range(126, 400));
    apply_config(lim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_frame(OP_BIN, 1'b1, 3'($urandom_range(0, 7)), need_mask, {1'b0, lim}, 1'b0, 1'b0);
    random_phase(250);
    settle();

    fatal_code = 3'($urandom_range(ST_BAD_OP, ST_BAD_UTF8));
    send_fatal(fatal_code);
    repeat (20) push_byte(8'($urandom_range(0, 255)));
    settle();

    $display("covered %0d bytes, %0d good frames, %0d items checked, %0d mismatches",
             bytes_sent, frames_sent, results_seen, mismatch_count);
    $display("final frame halted the parser with status %0d; later bytes gave no items",
             fatal_code);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // about 1.7k bytes; the timeout lies far past the slowest run
  initial begin
    #1000000;
    $display("timeout with %0d items still expected", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/core/ws_dfrm_pkg.sv
rtl/core/websocket_frame_deframer.sv
verif/tb_top.sv
